// ----- rtl/ffba_pkg.sv -----
package ffba_pkg;

	// Field widths of the request and result.
	localparam int COUNT_W  = 10;
	localparam int START_W  = 10;
	localparam int STATUS_W = 2;

	// Bitmap storage is organized in 32-bit words and scanned one byte at a time.
	localparam int WORD_W   = 32;
	localparam int OFF_W    = 5;
	localparam int BYTE_W   = 8;
	localparam int BSEL_W   = 2;

	// Default pool sizes.
	localparam int DEF_RT_BLOCKS   = 64;
	localparam int DEF_USER_BLOCKS = 960;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Pool codes.
	localparam logic POOL_RT   = 1'b0;
	localparam logic POOL_USER = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOOBIG = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                load;
		logic                scan_init;
		logic                scan_rd;
		logic                scan_step;
		logic                mark_alloc;
		logic                mark_free;
		logic                mark_rd;
		logic                mark_wr;
		logic                set_st;
		logic [STATUS_W-1:0] st_code;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_free;
		logic free_empty;
		logic too_big;
		logic zero_cnt;
		logic found;
		logic scan_end;
		logic byte_last;
		logic mark_last;
	} sts_t;

endpackage

// ----- rtl/ffba_map_ram.sv -----
module ffba_map_ram #(
	parameter int BLOCKS = ffba_pkg::DEF_RT_BLOCKS,
	parameter int WORDS  = (BLOCKS + ffba_pkg::WORD_W - 1) / ffba_pkg::WORD_W,
	parameter int AW     = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [ffba_pkg::WORD_W-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [ffba_pkg::WORD_W-1:0] wr_data
);

	logic [ffba_pkg::WORD_W-1:0] mem [WORDS];
	logic [WORDS-1:0]            valid_q;
	logic [ffba_pkg::WORD_W-1:0] rd_data_q;

	// A word never written since reset reads as all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/ffba_datapath.sv -----
module ffba_datapath #(
	parameter int RT_BLOCKS   = ffba_pkg::DEF_RT_BLOCKS,
	parameter int USER_BLOCKS = ffba_pkg::DEF_USER_BLOCKS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffba_pkg::cmd_t                cmd,
	output ffba_pkg::sts_t                sts,
	input  logic                          op,
	input  logic                          pool,
	input  logic [ffba_pkg::COUNT_W-1:0]  block_count,
	input  logic [ffba_pkg::START_W-1:0]  start_block,
	output logic [ffba_pkg::STATUS_W-1:0] status,
	output logic [ffba_pkg::START_W-1:0]  run_start
);

	localparam int MAXB   = (RT_BLOCKS > USER_BLOCKS) ? RT_BLOCKS : USER_BLOCKS;
	localparam int IW_MIN = $clog2(MAXB + ffba_pkg::BYTE_W);
	// Wide enough for any bit pointer and for start plus count.
	localparam int IW     = (IW_MIN > 11) ? IW_MIN : 11;
	localparam int WPW    = IW - ffba_pkg::OFF_W;
	localparam int RT_WORDS = (RT_BLOCKS + ffba_pkg::WORD_W - 1) / ffba_pkg::WORD_W;
	localparam int US_WORDS = (USER_BLOCKS + ffba_pkg::WORD_W - 1) / ffba_pkg::WORD_W;
	localparam int RT_AW  = (RT_WORDS > 1) ? $clog2(RT_WORDS) : 1;
	localparam int US_AW  = (US_WORDS > 1) ? $clog2(US_WORDS) : 1;
	localparam logic [ffba_pkg::WORD_W-1:0] ONES = '1;

	logic                          op_q;
	logic                          pool_q;
	logic [ffba_pkg::COUNT_W-1:0]  count_q;
	logic [ffba_pkg::START_W-1:0]  start_q;
	logic [ffba_pkg::STATUS_W-1:0] status_q;
	logic [ffba_pkg::START_W-1:0]  run_start_q;

	logic [IW-1:0]                 ptr_q;
	logic [ffba_pkg::COUNT_W-1:0]  run_q;
	logic [IW-1:0]                 first_q;
	logic [IW-1:0]                 lo_q;
	logic [IW-1:0]                 end_q;
	logic [WPW-1:0]                mw_q;

	logic [IW-1:0]                 size_v;
	logic [IW-1:0]                 count_x;
	logic [IW-1:0]                 start_x;
	logic [IW-1:0]                 free_end;
	logic [IW-1:0]                 ptr_nxt;
	logic [IW-1:0]                 alloc_end;
	logic [IW-1:0]                 last_idx;
	logic [WPW-1:0]                scan_word;
	logic [ffba_pkg::WORD_W-1:0]   rd_word;
	logic [ffba_pkg::WORD_W-1:0]   rt_rd_data;
	logic [ffba_pkg::WORD_W-1:0]   us_rd_data;
	logic [ffba_pkg::BYTE_W-1:0]   byte_v;
	logic [ffba_pkg::COUNT_W-1:0]  run_v;
	logic [IW-1:0]                 first_v;
	logic [IW-1:0]                 idx_v;
	logic                          found_v;
	logic [ffba_pkg::OFF_W-1:0]    lo_off;
	logic [ffba_pkg::OFF_W-1:0]    hi_off;
	logic [ffba_pkg::WORD_W-1:0]   mask;
	logic [ffba_pkg::WORD_W-1:0]   wr_word;
	logic                          any_rd;
	logic [WPW-1:0]                rd_word_addr;

	assign size_v   = pool_q ? IW'(USER_BLOCKS) : IW'(RT_BLOCKS);
	assign count_x  = IW'(count_q);
	assign start_x  = IW'(start_q);
	assign free_end = ((start_x + count_x) > size_v) ? size_v : (start_x + count_x);
	assign ptr_nxt  = ptr_q + IW'(ffba_pkg::BYTE_W);
	assign alloc_end = first_q + count_x;
	assign last_idx = end_q - IW'(1);

	assign sts.is_free    = (op_q == ffba_pkg::OP_FREE);
	assign sts.free_empty = (start_x >= size_v) || (count_q == '0);
	assign sts.too_big    = (count_x > size_v);
	assign sts.zero_cnt   = (count_q == '0);
	assign sts.found      = found_v;
	assign sts.scan_end   = (ptr_nxt >= size_v);
	assign sts.byte_last  = (ptr_q[ffba_pkg::OFF_W-1 -: ffba_pkg::BSEL_W] == '1);
	assign sts.mark_last  = (mw_q == last_idx[IW-1:ffba_pkg::OFF_W]);

	// One byte of the bitmap per scan step: track the current free run.
	assign rd_word = pool_q ? us_rd_data : rt_rd_data;
	assign byte_v  = ffba_pkg::BYTE_W'(rd_word >> {ptr_q[ffba_pkg::OFF_W-1:0]});

	always_comb begin
		run_v   = run_q;
		first_v = first_q;
		found_v = 1'b0;
		idx_v   = ptr_q;
		for (int k = 0; k < ffba_pkg::BYTE_W; k++) begin
			idx_v = ptr_q + IW'(k);
			if ((idx_v < size_v) && !found_v) begin
				if (!byte_v[k]) begin
					if (run_v == '0) begin
						first_v = idx_v;
					end
					run_v = run_v + ffba_pkg::COUNT_W'(1);
					if (run_v == count_q) begin
						found_v = 1'b1;
					end
				end else begin
					run_v = '0;
				end
			end
		end
	end

	// Mask of the run bits that fall in the word being marked.
	always_comb begin
		lo_off = (mw_q == lo_q[IW-1:ffba_pkg::OFF_W]) ? lo_q[ffba_pkg::OFF_W-1:0] : '0;
		hi_off = sts.mark_last ? last_idx[ffba_pkg::OFF_W-1:0] : '1;
		mask   = (ONES << lo_off) & (ONES >> (ffba_pkg::OFF_W'(ffba_pkg::WORD_W - 1) - hi_off));
		wr_word = sts.is_free ? (rd_word & ~mask) : (rd_word | mask);
	end

	assign scan_word    = cmd.scan_step ? ptr_nxt[IW-1:ffba_pkg::OFF_W]
	                                    : ptr_q[IW-1:ffba_pkg::OFF_W];
	assign rd_word_addr = cmd.mark_rd ? mw_q : scan_word;
	assign any_rd       = cmd.scan_rd || cmd.mark_rd;

	ffba_map_ram #(
		.BLOCKS(RT_BLOCKS)
	) u_rt_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (any_rd && (pool_q == ffba_pkg::POOL_RT)),
		.rd_addr (RT_AW'(rd_word_addr)),
		.rd_data (rt_rd_data),
		.wr_en   (cmd.mark_wr && (pool_q == ffba_pkg::POOL_RT)),
		.wr_addr (RT_AW'(mw_q)),
		.wr_data (wr_word)
	);

	ffba_map_ram #(
		.BLOCKS(USER_BLOCKS)
	) u_user_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (any_rd && (pool_q == ffba_pkg::POOL_USER)),
		.rd_addr (US_AW'(rd_word_addr)),
		.rd_data (us_rd_data),
		.wr_en   (cmd.mark_wr && (pool_q == ffba_pkg::POOL_USER)),
		.wr_addr (US_AW'(mw_q)),
		.wr_data (wr_word)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= op;
			pool_q      <= pool;
			count_q     <= block_count;
			start_q     <= start_block;
			status_q    <= ffba_pkg::ST_OK;
			run_start_q <= '0;
		end
		if (cmd.set_st) begin
			status_q <= cmd.st_code;
		end
		if (cmd.scan_init) begin
			ptr_q   <= '0;
			run_q   <= '0;
			first_q <= '0;
		end else if (cmd.scan_step) begin
			ptr_q   <= ptr_nxt;
			run_q   <= run_v;
			first_q <= first_v;
		end
		if (cmd.mark_alloc) begin
			lo_q        <= first_q;
			end_q       <= alloc_end;
			mw_q        <= first_q[IW-1:ffba_pkg::OFF_W];
			run_start_q <= first_q[ffba_pkg::START_W-1:0];
		end else if (cmd.mark_free) begin
			lo_q  <= start_x;
			end_q <= free_end;
			mw_q  <= start_x[IW-1:ffba_pkg::OFF_W];
		end else if (cmd.mark_wr) begin
			mw_q <= mw_q + WPW'(1);
		end
	end

	assign status    = status_q;
	assign run_start = run_start_q;

endmodule

// ----- rtl/ffba_ctrl.sv -----
module ffba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output ffba_pkg::cmd_t cmd,
	input  ffba_pkg::sts_t sts
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CHECK    = 3'd1;
	localparam logic [2:0] S_SCAN_RD  = 3'd2;
	localparam logic [2:0] S_SCAN     = 3'd3;
	localparam logic [2:0] S_MARK_SET = 3'd4;
	localparam logic [2:0] S_MARK_RD  = 3'd5;
	localparam logic [2:0] S_MARK_WR  = 3'd6;
	localparam logic [2:0] S_DONE     = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign busy = (state_q != S_IDLE) && (state_q != S_DONE);
	assign done = (state_q == S_DONE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE, S_DONE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_CHECK;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			S_CHECK: begin
				if (sts.is_free) begin
					if (sts.free_empty) begin
						cmd.set_st  = 1'b1;
						cmd.st_code = ffba_pkg::ST_OK;
						state_nxt   = S_DONE;
					end else begin
						cmd.mark_free = 1'b1;
						state_nxt     = S_MARK_RD;
					end
				end else if (sts.too_big) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ffba_pkg::ST_TOOBIG;
					state_nxt   = S_DONE;
				end else if (sts.zero_cnt) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ffba_pkg::ST_NOFIT;
					state_nxt   = S_DONE;
				end else begin
					cmd.scan_init = 1'b1;
					state_nxt     = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_nxt   = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.found) begin
					state_nxt = S_MARK_SET;
				end else if (sts.scan_end) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ffba_pkg::ST_NOFIT;
					state_nxt   = S_DONE;
				end else if (sts.byte_last) begin
					// Fetch the next word while the last byte of this one is scanned.
					cmd.scan_rd = 1'b1;
				end
			end
			S_MARK_SET: begin
				cmd.mark_alloc = 1'b1;
				state_nxt      = S_MARK_RD;
			end
			S_MARK_RD: begin
				cmd.mark_rd = 1'b1;
				state_nxt   = S_MARK_WR;
			end
			S_MARK_WR: begin
				cmd.mark_wr = 1'b1;
				if (sts.mark_last) begin
					cmd.set_st  = 1'b1;
					cmd.st_code = ffba_pkg::ST_OK;
					state_nxt   = S_DONE;
				end else begin
					state_nxt = S_MARK_RD;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- rtl/first_fit_bitmap_allocator.sv -----
// First-fit allocator over two block pools, each kept as a used/free bitmap.
// A request is accepted at a rising edge where start is high and busy is low.
// It carries op (allocate or free), pool (realtime or user), block_count and
// start_block. Every request gives exactly one result: status and run_start
// are valid for the single cycle in which done is high, and the receiver
// takes them at the edge that ends that cycle. The receiver cannot stall.
// An allocate scans the chosen pool from block 0 for the first run of
// block_count free blocks, one byte of the bitmap per cycle, then marks the
// run used with a read-modify-write of each 32-bit word it covers, a read
// state followed by a write state. A free clears the run, clipped to the pool
// end, in the same way. A rejected or empty request goes from the check
// straight to done. The scan rate is set by the byte-wide run tracker and the
// single read port of each bitmap.
// A new request may be accepted in the cycle that done is high.
// Reset clears both bitmaps at once through per-word valid flags, so the
// block is ready in the first cycle after reset is released.
module first_fit_bitmap_allocator #(
	parameter int RT_BLOCKS   = ffba_pkg::DEF_RT_BLOCKS,
	parameter int USER_BLOCKS = ffba_pkg::DEF_USER_BLOCKS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic                          pool,
	input  logic [ffba_pkg::COUNT_W-1:0]  block_count,
	input  logic [ffba_pkg::START_W-1:0]  start_block,
	output logic                          done,
	output logic [ffba_pkg::STATUS_W-1:0] status,
	output logic [ffba_pkg::START_W-1:0]  run_start
);

	// Commands and status between the sequencer and the bitmap datapath.
	ffba_pkg::cmd_t cmd;
	ffba_pkg::sts_t sts;

	// The controller walks each request through check, scan and mark phases; a free skips the scan.
	ffba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	// The datapath holds the request, both bitmaps, the run tracker and the result.
	ffba_datapath #(
		.RT_BLOCKS   (RT_BLOCKS),
		.USER_BLOCKS (USER_BLOCKS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.pool        (pool),
		.block_count (block_count),
		.start_block (start_block),
		.status      (status),
		.run_start   (run_start)
	);

endmodule
